// ----- src/bbe_pkg.sv -----
package bbe_pkg;

  // Frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Field and counter widths
  localparam int COL_W     = $clog2(MAX_WIDTH);      // input / output column
  localparam int WID_W     = COL_W + 1;              // frame width, 1..MAX_WIDTH
  localparam int HGT_W     = $clog2(MAX_HEIGHT) + 1; // frame height, 1..MAX_HEIGHT
  localparam int ROW_W     = $clog2(MAX_HEIGHT) + 1; // input row runs to height + 1
  localparam int OUT_ROW_W = $clog2(MAX_HEIGHT);
  localparam int CFG_W     = 13;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;

  // Averaging arithmetic
  localparam int SUM_W     = 12;  // 9 * 255
  localparam int NUM_W     = 13;  // 2 * sum + count
  localparam int CNT_W     = 4;   // count is 1, 2, 3, 4, 6 or 9
  localparam int RCP_W     = 18;
  localparam int RCP_SHIFT = 18;
  localparam int PROD_W    = NUM_W + RCP_W;

  // Register reset values
  localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

  // Register indexes
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_FRAME_WIDTH  = 1'b0;
  localparam cfg_index_t CFG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef pixel_t [8:0]      window_t;
  typedef logic [8:0][CH_W-1:0] cells_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_FIN
  } seq_state_t;

  // Window / line store control
  typedef struct packed {
    logic             rd;     // read both line stores at addr
    logic             step;   // write back and shift the window
    logic             clear;  // zero the window
    logic             post;   // show the shifted window
    logic [COL_W-1:0] addr;
  } win_ctrl_t;

  // Channel lane control
  typedef struct packed {
    logic             sum_en;
    logic             mul_en;
    logic [8:0]       mask;
    logic [CNT_W-1:0] count;
    logic [RCP_W-1:0] recip;
  } lane_ctrl_t;

  // ceil(2^18 / (2 * count)); exact floor for every numerator below 2^13
  function automatic logic [RCP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
    logic [RCP_W-1:0] r;
    unique case (count)
      4'd1:    r = RCP_W'(131072);
      4'd2:    r = RCP_W'(65536);
      4'd3:    r = RCP_W'(43691);
      4'd4:    r = RCP_W'(32768);
      4'd6:    r = RCP_W'(21846);
      4'd9:    r = RCP_W'(14564);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/box_blur_3x3_edge_aware_core.sv -----
// 3x3 box blur on an RGB888 raster stream, one pixel per input transaction.
// Each output pixel is the rounded mean of its in-frame neighbours, so the
// divisor is 9 in the interior, 6 on an edge and 4 in a corner. Results come
// out in raster order and lag the input by one row plus one pixel; once the
// last pixel of the frame is in, send flush transactions (req_type = 1) until
// the transaction with frame_end set has come out. Flushes sent earlier are
// dropped. A transaction that produces a result passes through line store
// read, window step and sums, reciprocal multiply and output load; one that
// produces none ends after the window step. The block holds one transaction
// at a time, limited by the registered line store read followed by the
// multiplier stage; a result waiting in the output register does not stop
// the next input from being taken, only the load of its own result.
// Writing frame_width or frame_height restarts the frame.
module box_blur_3x3_edge_aware_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [bbe_pkg::CH_W-1:0]    red_in,
  input  logic [bbe_pkg::CH_W-1:0]    green_in,
  input  logic [bbe_pkg::CH_W-1:0]    blue_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bbe_pkg::CH_W-1:0]    red_out,
  output logic [bbe_pkg::CH_W-1:0]    green_out,
  output logic [bbe_pkg::CH_W-1:0]    blue_out,
  output logic                        frame_end,
  input  logic                        cfg_write,
  input  bbe_pkg::cfg_index_t         cfg_index,
  input  logic [bbe_pkg::CFG_W-1:0]   cfg_data
);
  import bbe_pkg::*;

  seq_state_t state, state_next;

  logic [WID_W-1:0]     frame_width;
  logic [HGT_W-1:0]     frame_height;
  logic [WID_W-1:0]     eff_w;
  logic [HGT_W-1:0]     eff_h;
  logic [COL_W-1:0]     in_column;
  logic [ROW_W-1:0]     in_row;
  logic [COL_W-1:0]     out_column;
  logic [OUT_ROW_W-1:0] out_row;
  logic [COL_W-1:0]     cur_col;
  logic [ROW_W-1:0]     cur_row;
  pixel_t               pix;
  logic [CNT_W-1:0]     cnt_q;
  logic [RCP_W-1:0]     rcp_q;

  logic                 accept;
  logic                 in_frame;
  logic                 ignore;
  logic                 emit;
  logic                 emit_pre;
  logic [2:0]           rok;
  logic [2:0]           cok;
  logic [8:0]           mask;
  logic [1:0]           nrows;
  logic [1:0]           ncols;
  logic [CNT_W-1:0]     count;
  logic                 col_last;
  logic                 out_col_last;
  logic                 fe;
  logic                 out_load;

  win_ctrl_t            win_ctrl;
  lane_ctrl_t           lane_ctrl;
  window_t              view;
  logic [2:0][CH_W-1:0] avg;

  // Saturated frame size
  always_comb begin
    if (frame_width == '0) begin
      eff_w = WID_W'(1);
    end else if (frame_width > WID_W'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = frame_width;
    end
    if (frame_height == '0) begin
      eff_h = HGT_W'(1);
    end else if (frame_height > HGT_W'(MAX_HEIGHT)) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = frame_height;
    end
  end

  // Input side decode
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_frame = (in_row < ROW_W'(eff_h));
  assign ignore   = in_frame && req_type;

  // Which neighbours count for the transaction in hand
  always_comb begin
    emit     = (cur_row >= ROW_W'(2)) || ((cur_row == ROW_W'(1)) && (cur_col != '0));
    emit_pre = emit && (cur_col == '0);
    if (emit_pre) begin
      // last column of the previous row, from the unshifted window
      rok[0] = (cur_row >= ROW_W'(3));
      rok[1] = 1'b1;
      rok[2] = (cur_row <= ROW_W'(eff_h));
      cok[0] = 1'b0;
      cok[1] = (eff_w >= WID_W'(2));
      cok[2] = 1'b1;
    end else begin
      rok[0] = (cur_row >= ROW_W'(2));
      rok[1] = 1'b1;
      rok[2] = (cur_row < ROW_W'(eff_h));
      cok[0] = (cur_col >= COL_W'(2));
      cok[1] = 1'b1;
      cok[2] = 1'b1;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mask[r*3 + c] = rok[r] && cok[c];
      end
    end
    nrows = {1'b0, rok[0]} + {1'b0, rok[1]} + {1'b0, rok[2]};
    ncols = {1'b0, cok[0]} + {1'b0, cok[1]} + {1'b0, cok[2]};
    count = {2'b00, nrows} * {2'b00, ncols};
  end

  // Position wrap and end of frame
  assign col_last     = (WID_W'(cur_col) + WID_W'(1)) >= eff_w;
  assign out_col_last = (WID_W'(out_column) + WID_W'(1)) >= eff_w;
  assign fe           = (HGT_W'(out_row) == eff_h - HGT_W'(1)) &&
                        (WID_W'(out_column) == eff_w - WID_W'(1));
  assign out_load     = (state == ST_FIN) && (!out_valid || !out_stall);

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    win_ctrl.rd      = 1'b0;
    win_ctrl.step    = 1'b0;
    win_ctrl.post    = 1'b0;
    win_ctrl.clear   = cfg_write || (out_load && fe);
    win_ctrl.addr    = (state == ST_READ) ? cur_col : in_column;
    lane_ctrl.sum_en = 1'b0;
    lane_ctrl.mul_en = 1'b0;
    lane_ctrl.mask   = mask;
    lane_ctrl.count  = cnt_q;
    lane_ctrl.recip  = rcp_q;
    unique case (state)
      ST_IDLE: begin
        win_ctrl.rd = accept;
        if (accept && !ignore) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        win_ctrl.step    = 1'b1;
        win_ctrl.post    = !emit_pre;
        lane_ctrl.sum_en = 1'b1;
        state_next       = emit ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        lane_ctrl.mul_en = 1'b1;
        state_next       = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Registers, positions and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width  <= cfg_data[WID_W-1:0];
          CFG_FRAME_HEIGHT: frame_height <= cfg_data[HGT_W-1:0];
          default:          frame_height <= frame_height;
        endcase
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (state == ST_READ) begin
          if (col_last) begin
            in_column <= '0;
            in_row    <= cur_row + ROW_W'(1);
          end else begin
            in_column <= cur_col + COL_W'(1);
          end
        end
        if (out_load) begin
          if (fe) begin
            in_column  <= '0;
            in_row     <= '0;
            out_column <= '0;
            out_row    <= '0;
          end else if (out_col_last) begin
            out_column <= '0;
            out_row    <= out_row + OUT_ROW_W'(1);
          end else begin
            out_column <= out_column + COL_W'(1);
          end
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_row <= in_row;
      cur_col <= in_column;
      pix     <= in_frame ? {red_in, green_in, blue_in} : '0;
    end
    if (state == ST_READ) begin
      cnt_q <= count;
      rcp_q <= recip_of(count);
    end
    if (out_load) begin
      red_out   <= avg[0];
      green_out <= avg[1];
      blue_out  <= avg[2];
      frame_end <= fe;
    end
  end

  bbe_window u_window (
    .clk  (clk),
    .rst  (rst),
    .ctrl (win_ctrl),
    .pix  (pix),
    .view (view)
  );

  // One lane per colour channel: red, green, blue
  for (genvar g = 0; g < 3; g++) begin : g_lane
    localparam int Shift = 2 * CH_W - g * CH_W;
    cells_t cells;

    always_comb begin
      for (int i = 0; i < 9; i++) begin
        cells[i] = view[i][Shift +: CH_W];
      end
    end

    bbe_lane u_lane (
      .clk   (clk),
      .cells (cells),
      .ctrl  (lane_ctrl),
      .avg   (avg[g])
    );
  end

endmodule

// ----- src/bbe_window.sv -----
module bbe_window (
  input  logic               clk,
  input  logic               rst,
  input  bbe_pkg::win_ctrl_t ctrl,
  input  bbe_pkg::pixel_t    pix,
  output bbe_pkg::window_t   view
);
  import bbe_pkg::*;

  pixel_t  line_a [MAX_WIDTH];
  pixel_t  line_b [MAX_WIDTH];
  pixel_t  above;
  pixel_t  prev;
  window_t win;
  window_t shifted;

  // Line stores: read on acceptance, written back on the step
  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      above <= line_a[ctrl.addr];
      prev  <= line_b[ctrl.addr];
    end
    if (ctrl.step) begin
      line_a[ctrl.addr] <= prev;
      line_b[ctrl.addr] <= pix;
    end
  end

  // Window after one column shift
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shifted[r*3]     = win[r*3 + 1];
      shifted[r*3 + 1] = win[r*3 + 2];
    end
    shifted[2] = above;
    shifted[5] = prev;
    shifted[8] = pix;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      win <= '0;
    end else if (ctrl.step) begin
      win <= shifted;
    end
  end

  assign view = ctrl.post ? shifted : win;

endmodule

// ----- src/bbe_lane.sv -----
module bbe_lane (
  input  logic                      clk,
  input  bbe_pkg::cells_t           cells,
  input  bbe_pkg::lane_ctrl_t       ctrl,
  output logic [bbe_pkg::CH_W-1:0]  avg
);
  import bbe_pkg::*;

  logic [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]  sum;
  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;

  // Masked neighbourhood sum
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < 9; i++) begin
      if (ctrl.mask[i]) begin
        sum_next = sum_next + SUM_W'(cells[i]);
      end
    end
  end

  // Rounded mean: (2*sum + count) / (2*count) by reciprocal multiply
  assign num = {sum, 1'b0} + NUM_W'(ctrl.count);

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      sum <= sum_next;
    end
    if (ctrl.mul_en) begin
      prod <= PROD_W'(num) * PROD_W'(ctrl.recip);
    end
  end

  assign avg = prod[RCP_SHIFT +: CH_W];

endmodule

// ----- src/bbe_checker.sv -----
module bbe_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       req_type,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bbe_pkg::CH_W-1:0]   red_out,
  input logic [bbe_pkg::CH_W-1:0]   green_out,
  input logic [bbe_pkg::CH_W-1:0]   blue_out,
  input logic                       frame_end
);

  // A pixel transaction is never dropped: the block goes busy behind it
  a_pixel_taken: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !req_type |=> in_stall)
    else $error("pixel transaction did not start processing");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A new result is loaded only while the input side is busy
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in hand");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable({red_out, green_out, blue_out, frame_end}))
    else $error("stalled result changed");

endmodule

bind box_blur_3x3_edge_aware_core bbe_checker u_checker (.*);
